/* design/mldf_pkg.sv */
package mldf_pkg;

    localparam logic [15:0] MAGIC_WORD_RESET       = 16'h5A5A;
    localparam logic [7:0]  EXPECTED_VERSION_RESET = 8'h01;
    localparam int          QUEUE_DEPTH            = 4;

    // configuration register indexes
    localparam logic CFG_MAGIC_WORD       = 1'b0;
    localparam logic CFG_EXPECTED_VERSION = 1'b1;

    // header byte positions after the marker
    localparam logic [2:0] HDR_VERSION  = 3'd0;
    localparam logic [2:0] HDR_TYPE_HI  = 3'd1;
    localparam logic [2:0] HDR_TYPE_LO  = 3'd2;
    localparam logic [2:0] HDR_LEN_HI   = 3'd3;
    localparam logic [2:0] HDR_LEN_LO   = 3'd4;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_HEADER,
        PH_DATA,
        PH_SKIP
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_EMPTY,
        KIND_MISMATCH
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] packet_type;
        logic [15:0] payload_length;
        logic [7:0]  data;
        logic        first;
        logic        last;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

/* design/mldf_front.sv */
module mldf_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [15:0]            cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   op,
    input  logic [7:0]             rx_byte,
    input  mldf_pkg::queue_status_t queue_st,
    output logic                   push,
    output mldf_pkg::entry_t       push_entry
);

    logic [15:0]      magic_word_reg;
    logic [7:0]       expected_version_reg;

    mldf_pkg::phase_t phase_reg, phase_next;
    logic [7:0]       previous_byte_reg, previous_byte_next;
    logic             prev_valid_reg, prev_valid_next;
    logic [2:0]       header_index_reg, header_index_next;
    logic [7:0]       hdr_version_reg, hdr_version_next;
    logic [15:0]      hdr_type_reg, hdr_type_next;
    logic [15:0]      hdr_length_reg, hdr_length_next;
    logic [15:0]      bytes_left_reg, bytes_left_next;

    logic             accept;
    logic [15:0]      final_length;
    logic [15:0]      bytes_left_dec;

    assign in_stall       = queue_st.full;
    assign accept         = in_valid && !in_stall;
    assign final_length   = {hdr_length_reg[15:8], rx_byte};
    assign bytes_left_dec = 16'(bytes_left_reg - 16'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_word_reg       <= mldf_pkg::MAGIC_WORD_RESET;
            expected_version_reg <= mldf_pkg::EXPECTED_VERSION_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mldf_pkg::CFG_MAGIC_WORD:       magic_word_reg       <= cfg_data;
                mldf_pkg::CFG_EXPECTED_VERSION: expected_version_reg <= cfg_data[7:0];
                default:                        magic_word_reg       <= magic_word_reg;
            endcase
        end
    end

    // next state
    always_comb
    begin
        phase_next         = phase_reg;
        previous_byte_next = previous_byte_reg;
        prev_valid_next    = prev_valid_reg;
        header_index_next  = header_index_reg;
        hdr_version_next   = hdr_version_reg;
        hdr_type_next      = hdr_type_reg;
        hdr_length_next    = hdr_length_reg;
        bytes_left_next    = bytes_left_reg;
        if (accept)
        begin
            if (op)
            begin
                phase_next         = mldf_pkg::PH_HUNT;
                previous_byte_next = 8'd0;
                prev_valid_next    = 1'b0;
                header_index_next  = 3'd0;
                hdr_version_next   = 8'd0;
                hdr_type_next      = 16'd0;
                hdr_length_next    = 16'd0;
                bytes_left_next    = 16'd0;
            end
            else
            begin
                unique case (phase_reg)
                    mldf_pkg::PH_HUNT:
                    begin
                        if (prev_valid_reg && {previous_byte_reg, rx_byte} == magic_word_reg)
                        begin
                            phase_next         = mldf_pkg::PH_HEADER;
                            header_index_next  = 3'd0;
                            prev_valid_next    = 1'b0;
                            previous_byte_next = 8'd0;
                        end
                        else
                        begin
                            previous_byte_next = rx_byte;
                            prev_valid_next    = 1'b1;
                        end
                    end
                    mldf_pkg::PH_HEADER:
                    begin
                        unique case (header_index_reg)
                            mldf_pkg::HDR_VERSION: hdr_version_next = rx_byte;
                            mldf_pkg::HDR_TYPE_HI: hdr_type_next    = {rx_byte, hdr_type_reg[7:0]};
                            mldf_pkg::HDR_TYPE_LO: hdr_type_next    = {hdr_type_reg[15:8], rx_byte};
                            mldf_pkg::HDR_LEN_HI:  hdr_length_next  = {rx_byte, hdr_length_reg[7:0]};
                            default:               hdr_length_next  = final_length;
                        endcase
                        if (header_index_reg < mldf_pkg::HDR_LEN_LO)
                        begin
                            header_index_next = 3'(header_index_reg + 3'd1);
                        end
                        else
                        begin
                            header_index_next = 3'd0;
                            bytes_left_next   = final_length;
                            if (hdr_version_reg != expected_version_reg)
                            begin
                                phase_next = (final_length != 16'd0) ? mldf_pkg::PH_SKIP
                                                                     : mldf_pkg::PH_HUNT;
                            end
                            else if (final_length == 16'd0)
                            begin
                                phase_next = mldf_pkg::PH_HUNT;
                            end
                            else
                            begin
                                phase_next = mldf_pkg::PH_DATA;
                            end
                        end
                    end
                    mldf_pkg::PH_DATA:
                    begin
                        bytes_left_next = bytes_left_dec;
                        if (bytes_left_reg <= 16'd1)
                        begin
                            phase_next = mldf_pkg::PH_HUNT;
                        end
                    end
                    default:
                    begin
                        bytes_left_next = bytes_left_dec;
                        if (bytes_left_dec == 16'd0)
                        begin
                            phase_next = mldf_pkg::PH_HUNT;
                        end
                    end
                endcase
            end
        end
    end

    // result classification
    always_comb
    begin
        push                      = 1'b0;
        push_entry.kind           = mldf_pkg::KIND_DATA;
        push_entry.packet_type    = hdr_type_reg;
        push_entry.payload_length = hdr_length_reg;
        push_entry.data           = rx_byte;
        push_entry.first          = (bytes_left_reg == hdr_length_reg);
        push_entry.last           = (bytes_left_reg <= 16'd1);
        if (accept && !op)
        begin
            if (phase_reg == mldf_pkg::PH_DATA)
            begin
                push = 1'b1;
            end
            else if (phase_reg == mldf_pkg::PH_HEADER &&
                     header_index_reg >= mldf_pkg::HDR_LEN_LO)
            begin
                push_entry.payload_length = final_length;
                push_entry.first          = 1'b1;
                push_entry.last           = 1'b1;
                if (hdr_version_reg != expected_version_reg)
                begin
                    push            = 1'b1;
                    push_entry.kind = mldf_pkg::KIND_MISMATCH;
                end
                else if (final_length == 16'd0)
                begin
                    push            = 1'b1;
                    push_entry.kind = mldf_pkg::KIND_EMPTY;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= mldf_pkg::PH_HUNT;
            previous_byte_reg <= 8'd0;
            prev_valid_reg    <= 1'b0;
            header_index_reg  <= 3'd0;
            hdr_version_reg   <= 8'd0;
            hdr_type_reg      <= 16'd0;
            hdr_length_reg    <= 16'd0;
            bytes_left_reg    <= 16'd0;
        end
        else
        begin
            phase_reg         <= phase_next;
            previous_byte_reg <= previous_byte_next;
            prev_valid_reg    <= prev_valid_next;
            header_index_reg  <= header_index_next;
            hdr_version_reg   <= hdr_version_next;
            hdr_type_reg      <= hdr_type_next;
            hdr_length_reg    <= hdr_length_next;
            bytes_left_reg    <= bytes_left_next;
        end
    end

endmodule

/* design/mldf_queue.sv */
module mldf_queue #(
    parameter int DEPTH = mldf_pkg::QUEUE_DEPTH
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  mldf_pkg::entry_t        push_entry,
    input  logic                    pop,
    output mldf_pkg::entry_t        head,
    output mldf_pkg::queue_status_t queue_st
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    mldf_pkg::entry_t slots_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign queue_st.full  = (count_reg == CW'(DEPTH));
    assign queue_st.empty = (count_reg == '0);
    assign do_push        = push && !queue_st.full;
    assign do_pop         = pop && !queue_st.empty;
    assign head           = slots_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = CW'(count_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_reg + 1'b1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* design/mldf_back.sv */
module mldf_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  mldf_pkg::entry_t        head,
    input  mldf_pkg::queue_status_t queue_st,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    status,
    output logic [15:0]             packet_type,
    output logic [15:0]             payload_length,
    output logic [7:0]              payload_byte,
    output logic                    byte_valid,
    output logic                    first_mark,
    output logic                    last_mark
);

    logic        out_valid_reg;
    logic        status_reg, status_next;
    logic [15:0] packet_type_reg;
    logic [15:0] payload_length_reg;
    logic [7:0]  payload_byte_reg, payload_byte_next;
    logic        byte_valid_reg, byte_valid_next;
    logic        first_mark_reg, first_mark_next;
    logic        last_mark_reg, last_mark_next;

    assign pop = !queue_st.empty && (!out_valid_reg || !out_stall);

    // expand the queued record into result fields
    always_comb
    begin
        unique case (head.kind)
            mldf_pkg::KIND_DATA:
            begin
                status_next       = 1'b0;
                payload_byte_next = head.data;
                byte_valid_next   = 1'b1;
                first_mark_next   = head.first;
                last_mark_next    = head.last;
            end
            mldf_pkg::KIND_MISMATCH:
            begin
                status_next       = 1'b1;
                payload_byte_next = 8'd0;
                byte_valid_next   = 1'b0;
                first_mark_next   = 1'b1;
                last_mark_next    = 1'b1;
            end
            default:
            begin
                status_next       = 1'b0;
                payload_byte_next = 8'd0;
                byte_valid_next   = 1'b0;
                first_mark_next   = 1'b1;
                last_mark_next    = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg         <= status_next;
            packet_type_reg    <= head.packet_type;
            payload_length_reg <= head.payload_length;
            payload_byte_reg   <= payload_byte_next;
            byte_valid_reg     <= byte_valid_next;
            first_mark_reg     <= first_mark_next;
            last_mark_reg      <= last_mark_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign packet_type    = packet_type_reg;
    assign payload_length = payload_length_reg;
    assign payload_byte   = payload_byte_reg;
    assign byte_valid     = byte_valid_reg;
    assign first_mark     = first_mark_reg;
    assign last_mark      = last_mark_reg;

endmodule

/* design/magic_length_packet_deframer_core.sv */
// Path: a record for the byte that causes a result is written into the result queue when
//   that byte is accepted, and the output register loads the record when it is popped.
// Throughput: one byte per clock while the queue is not full; the parser updates counters
//   and compares only; queue plus output register sustain one result per clock unstalled.
// Reset: rst_n is asynchronous, active low; it returns the parser to marker hunting, empties
//   the result queue and loads the default marker and expected version.
module magic_length_packet_deframer_core #(
    parameter int QUEUE_DEPTH = mldf_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration writes, index 0 = magic word, 1 = expected version
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    // input transactions
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [7:0]  rx_byte,
    // result transactions
    output logic        out_valid,
    input  logic        out_stall,
    output logic        status,
    output logic [15:0] packet_type,
    output logic [15:0] payload_length,
    output logic [7:0]  payload_byte,
    output logic        byte_valid,
    output logic        first_mark,
    output logic        last_mark
);

    // Front: hunts the marker, collects the header and classifies each byte.
    // Only payload bytes, empty packets and version mismatches push a record.
    mldf_pkg::queue_status_t queue_st;
    mldf_pkg::entry_t        push_entry;
    mldf_pkg::entry_t        head;
    logic                    push;
    logic                    pop;

    mldf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .rx_byte    (rx_byte),
        .queue_st   (queue_st),
        .push       (push),
        .push_entry (push_entry)
    );

    // Short queue decouples the parser from output back-pressure; the input
    // stalls only once the queue is full.
    mldf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .queue_st   (queue_st)
    );

    // Back: expands the queued record into result fields in an output register.
    mldf_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .queue_st       (queue_st),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .packet_type    (packet_type),
        .payload_length (payload_length),
        .payload_byte   (payload_byte),
        .byte_valid     (byte_valid),
        .first_mark     (first_mark),
        .last_mark      (last_mark)
    );

endmodule

/* design/mldf_checker.sv */
module mldf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        status,
    input logic [15:0] packet_type,
    input logic [15:0] payload_length,
    input logic [7:0]  payload_byte,
    input logic        byte_valid,
    input logic        first_mark,
    input logic        last_mark
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result transaction dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(payload_byte) && $stable(packet_type) &&
                                   $stable(payload_length) && $stable(status))
        else $error("stalled result changed");

    a_nodata_marks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> first_mark && last_mark)
        else $error("data-less result must be both first and last");

    a_mismatch_nodata: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> !byte_valid && payload_byte == 8'd0)
        else $error("version mismatch result carries data");

    a_nodata_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> payload_byte == 8'd0)
        else $error("payload byte not zero without data");

endmodule

bind magic_length_packet_deframer_core mldf_checker u_mldf_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .packet_type    (packet_type),
    .payload_length (payload_length),
    .payload_byte   (payload_byte),
    .byte_valid     (byte_valid),
    .first_mark     (first_mark),
    .last_mark      (last_mark)
);
